// File: sv/pgmf_pkg.sv
// pgmf_pkg: shared types and constants for the pcm gain/mute/fade core
// used by the interfaces, front end, queue, back end, top level and checker
// no dependencies

package pgmf_pkg;

  // field widths
  localparam int CH_W       = 3;
  localparam int SAMPLE_W   = 32;
  localparam int COEFF_W    = 16;
  localparam int FRAMES_W   = 16;
  localparam int ENV_W      = 64;
  localparam int STEP_W     = 63;
  localparam int COUNT_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 63;

  // depth of the queue between front and back end
  localparam int QUEUE_DEPTH = 2;

  localparam logic [COEFF_W-1:0] UNITY_COEFF = 16'd1024;

  // command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_COEFF  = 1'b1;

  // gain mode codes
  localparam logic [1:0] MODE_STATIC = 2'd0;
  localparam logic [1:0] MODE_MUTE   = 2'd1;
  localparam logic [1:0] MODE_FADE   = 2'd2;

  // envelope direction codes
  localparam logic DIR_UP   = 1'b0;
  localparam logic DIR_DOWN = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENV_DIR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_MODE = 2'd3;

  // operation handed from front to back end
  typedef enum logic [2:0] {
    OP_COEFF  = 3'd0,
    OP_STATIC = 3'd1,
    OP_MUTE   = 3'd2,
    OP_FADE   = 3'd3,
    OP_PASS   = 3'd4
  } op_t;

  // configuration as seen by front and back end
  typedef struct packed {
    logic [1:0]        gain_mode;
    logic              envelope_dir;
    logic [STEP_W-1:0] fade_step;
    logic              wide;
  } cfg_t;

  // one queued item
  typedef struct packed {
    op_t                  op;
    logic [CH_W-1:0]      channel;
    logic [SAMPLE_W-1:0]  x;
    logic [COEFF_W-1:0]   coeff_value;
    logic                 block_end;
    logic [FRAMES_W-1:0]  block_frames;
  } entry_t;

endpackage

// File: sv/pgmf_in_if.sv
// pgmf_in_if: input channel of the pcm gain/mute/fade core
// valid/ready handshake with the input item fields; depends on pgmf_pkg

interface pgmf_in_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic [pgmf_pkg::CH_W-1:0]           channel;
  logic signed [pgmf_pkg::SAMPLE_W-1:0] sample_in;
  logic signed [pgmf_pkg::COEFF_W-1:0] coeff_value;
  logic                                block_end;
  logic [pgmf_pkg::FRAMES_W-1:0]       block_frames;

  modport source (
    output valid, cmd, channel, sample_in, coeff_value, block_end, block_frames,
    input  ready
  );
  modport sink (
    input  valid, cmd, channel, sample_in, coeff_value, block_end, block_frames,
    output ready
  );
endinterface

// File: sv/pgmf_out_if.sv
// pgmf_out_if: result channel of the pcm gain/mute/fade core
// valid/ready handshake with the result fields; depends on pgmf_pkg

interface pgmf_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pgmf_pkg::SAMPLE_W-1:0] sample_out;
  logic [pgmf_pkg::CH_W-1:0]            out_channel;
  logic                                 out_block_end;
  logic [pgmf_pkg::COUNT_W-1:0]         fade_frames_done;

  modport source (
    output valid, sample_out, out_channel, out_block_end, fade_frames_done,
    input  ready
  );
  modport sink (
    input  valid, sample_out, out_channel, out_block_end, fade_frames_done,
    output ready
  );
endinterface

// File: sv/pcm_gain_mute_fade_core.sv
// pcm_gain_mute_fade_core: top level of the per-channel pcm gain/mute/fade block
// depends on pgmf_pkg, pgmf_in_if, pgmf_out_if, pgmf_front, pgmf_queue, pgmf_back

// Per-channel PCM gain with mute and quadratic fade. Each sample transaction
// (cmd 0) yields one result; a coefficient transaction (cmd 1) writes the
// channel's Q10 gain and yields none. The front end classifies each transaction
// by the current gain mode and pushes it into a two-entry queue, so input keeps
// flowing while the back end works or a result waits. The back end handles one
// entry at a time with a shared sequence of registered multiplies: a coefficient
// write ends at the idle pop, mute and unused mode go straight to the result
// load, static gain adds the sample product, and fade runs idle pop, envelope
// square, gain product, sample product, result load; stalls hold the result load.
// At a block end in fade mode the envelope moves by fade_step times the block's
// frames, computed as 32x16 and 31x16 partial products summed before the
// envelope add. Configuration is written through cfg_we/cfg_index/cfg_data and
// must only change while the block is idle. After reset all coefficients are
// unity (1024), the envelope and counters are zero and samples are 32-bit.

module pcm_gain_mute_fade_core #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [pgmf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pgmf_pkg::CFG_DATA_W-1:0]    cfg_data,
  pgmf_in_if.sink                            in,
  pgmf_out_if.source                         out
);

  // configuration registers
  logic [1:0]                  gain_mode;
  logic                        envelope_dir;
  logic [pgmf_pkg::STEP_W-1:0] fade_step;
  logic                        sample_width_mode;

  pgmf_pkg::cfg_t   cfg;
  pgmf_pkg::entry_t push_data;
  pgmf_pkg::entry_t head;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_mode         <= pgmf_pkg::MODE_STATIC;
      envelope_dir      <= pgmf_pkg::DIR_UP;
      fade_step         <= '0;
      sample_width_mode <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        pgmf_pkg::REG_GAIN_MODE:  gain_mode         <= cfg_data[1:0];
        pgmf_pkg::REG_ENV_DIR:    envelope_dir      <= cfg_data[0];
        pgmf_pkg::REG_FADE_STEP:  fade_step         <= cfg_data;
        pgmf_pkg::REG_WIDTH_MODE: sample_width_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.gain_mode    = gain_mode;
    cfg.envelope_dir = envelope_dir;
    cfg.fade_step    = fade_step;
    cfg.wide         = sample_width_mode;
  end

  // classification, no state
  pgmf_front u_front (
    .rst       (rst),
    .cfg       (cfg),
    .in        (in),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // decouples acceptance from execution
  pgmf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  // coefficient table, multiply sequence, envelope, result register
  pgmf_back #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .out     (out)
  );

endmodule

// File: sv/pgmf_front.sv
// pgmf_front: accepts input transactions and classifies them into queue entries
// depends on pgmf_pkg and pgmf_in_if

module pgmf_front (
  input  logic              rst,
  input  pgmf_pkg::cfg_t    cfg,
  pgmf_in_if.sink           in,
  input  logic              q_full,
  output logic              push,
  output pgmf_pkg::entry_t  push_data
);

  pgmf_pkg::op_t op;

  assign in.ready = !q_full && !rst;
  assign push     = in.valid && in.ready;

  always_comb begin
    if (in.cmd == pgmf_pkg::CMD_COEFF) begin
      op = pgmf_pkg::OP_COEFF;
    end else begin
      case (cfg.gain_mode)
        pgmf_pkg::MODE_STATIC: op = pgmf_pkg::OP_STATIC;
        pgmf_pkg::MODE_MUTE:   op = pgmf_pkg::OP_MUTE;
        pgmf_pkg::MODE_FADE:   op = pgmf_pkg::OP_FADE;
        default:               op = pgmf_pkg::OP_PASS;
      endcase
    end
  end

  always_comb begin
    push_data.op           = op;
    push_data.channel      = in.channel;
    // sixteen-bit mode keeps only the low half, sign extended
    push_data.x            = cfg.wide ? in.sample_in
                                      : {{16{in.sample_in[15]}}, in.sample_in[15:0]};
    push_data.coeff_value  = in.coeff_value;
    push_data.block_end    = in.block_end;
    push_data.block_frames = in.block_frames;
  end

endmodule

// File: sv/pgmf_queue.sv
// pgmf_queue: short fifo of classified entries between front and back end
// depends on pgmf_pkg

module pgmf_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pgmf_pkg::entry_t  push_data,
  output logic              full,
  input  logic              pop,
  output pgmf_pkg::entry_t  head,
  output logic              empty
);

  localparam int PTR_W = (pgmf_pkg::QUEUE_DEPTH > 1) ? $clog2(pgmf_pkg::QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(pgmf_pkg::QUEUE_DEPTH - 1);
  localparam logic [PTR_W:0]   FULL_CNT = (PTR_W + 1)'(pgmf_pkg::QUEUE_DEPTH);

  pgmf_pkg::entry_t entries [pgmf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: sv/pgmf_back.sv
// pgmf_back: executes queued entries: coefficient table, multiply sequence,
// envelope and frame counters, result register; depends on pgmf_pkg, pgmf_out_if

module pgmf_back #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  pgmf_pkg::cfg_t    cfg,
  input  pgmf_pkg::entry_t  head,
  input  logic              q_empty,
  output logic              pop,
  pgmf_out_if.source        out
);

  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  localparam logic signed [47:0] SAT_HI_W = 48'sh0000_7FFF_FFFF;
  localparam logic signed [47:0] SAT_LO_W = -48'sh0000_8000_0000;
  localparam logic signed [47:0] SAT_HI_N = 48'sh0000_0000_7FFF;
  localparam logic signed [47:0] SAT_LO_N = -48'sh0000_0000_8000;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL1 = 5'b00010,
    S_MUL2 = 5'b00100,
    S_MUL3 = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [pgmf_pkg::COEFF_W-1:0] coeff_table [MAX_CHANNELS];
  logic [IDX_W-1:0]             head_idx;
  logic                         head_ch_ok;

  // item registers
  pgmf_pkg::op_t                  op_r;
  logic [pgmf_pkg::CH_W-1:0]      ch_r;
  logic signed [31:0]             x_r;
  logic                           bend_r;
  logic [pgmf_pkg::FRAMES_W-1:0]  frames_r;
  logic signed [15:0]             coeff_r;

  // multiply sequence registers
  logic signed [31:0] esq_r;
  logic [47:0]        dlo_r;
  logic [31:0]        dhi_r;
  logic signed [31:0] gp_r;
  logic [63:0]        d_r;
  logic signed [47:0] p_r;

  // state
  logic [pgmf_pkg::ENV_W-1:0]   envelope;
  logic [pgmf_pkg::COUNT_W-1:0] silence_frames;
  logic [pgmf_pkg::COUNT_W-1:0] fade_frames;

  logic signed [15:0] env_hi;
  logic signed [31:0] sq_t;
  logic signed [15:0] sq16;
  logic signed [31:0] g_t;
  logic signed [15:0] g16;
  logic signed [15:0] mul_g;
  logic signed [47:0] r48;
  logic signed [47:0] sat48;
  logic [31:0]        y;
  logic               out_free;

  logic                                 res_valid;
  logic signed [pgmf_pkg::SAMPLE_W-1:0] out_sample;
  logic [pgmf_pkg::CH_W-1:0]            out_ch;
  logic                                 out_bend;
  logic [pgmf_pkg::COUNT_W-1:0]         out_ffd;

  assign head_idx   = IDX_W'(head.channel);
  assign head_ch_ok = ({29'd0, head.channel} < 32'(MAX_CHANNELS));
  assign pop        = (state == S_IDLE) && !q_empty;
  assign out_free   = !res_valid || out.ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (pop) begin
          case (head.op)
            pgmf_pkg::OP_FADE:   state_next = S_MUL1;
            pgmf_pkg::OP_STATIC: state_next = S_MUL3;
            pgmf_pkg::OP_MUTE:   state_next = S_OUT;
            pgmf_pkg::OP_PASS:   state_next = S_OUT;
            default:             state_next = S_IDLE;
          endcase
        end
      end
      S_MUL1:  state_next = S_MUL2;
      S_MUL2:  state_next = S_MUL3;
      S_MUL3:  state_next = S_OUT;
      S_OUT:   state_next = out_free ? S_IDLE : S_OUT;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // coefficient table, unity after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        coeff_table[i] <= pgmf_pkg::UNITY_COEFF;
      end
    end else if (pop && head.op == pgmf_pkg::OP_COEFF && head_ch_ok) begin
      coeff_table[head_idx] <= head.coeff_value;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.op != pgmf_pkg::OP_COEFF) begin
      op_r     <= head.op;
      ch_r     <= head.channel;
      x_r      <= head.x;
      bend_r   <= head.block_end;
      frames_r <= head.block_frames;
      coeff_r  <= head_ch_ok ? coeff_table[head_idx] : pgmf_pkg::UNITY_COEFF;
    end
  end

  // rounding: ((v >>> (s-1)) + 1) >>> 1, square and gain wrapped to 16 bits
  assign env_hi = envelope[63:48];
  assign sq_t   = ((esq_r >>> 14) + 32'sd1) >>> 1;
  assign sq16   = sq_t[15:0];
  assign g_t    = ((gp_r >>> 14) + 32'sd1) >>> 1;
  assign g16    = g_t[15:0];
  assign mul_g  = (op_r == pgmf_pkg::OP_FADE) ? g16 : coeff_r;
  assign r48    = ((p_r >>> 9) + 48'sd1) >>> 1;

  always_comb begin
    if (cfg.wide) begin
      sat48 = (r48 > SAT_HI_W) ? SAT_HI_W : ((r48 < SAT_LO_W) ? SAT_LO_W : r48);
    end else begin
      sat48 = (r48 > SAT_HI_N) ? SAT_HI_N : ((r48 < SAT_LO_N) ? SAT_LO_N : r48);
    end
    case (op_r)
      pgmf_pkg::OP_MUTE: y = '0;
      pgmf_pkg::OP_PASS: y = x_r;
      default:           y = sat48[31:0];
    endcase
  end

  // the upper partial product only matters modulo 2^32 once shifted up by 32
  always_ff @(posedge clk) begin
    case (state)
      S_MUL1: begin
        esq_r <= 32'(env_hi) * 32'(env_hi);
        dlo_r <= 48'(cfg.fade_step[31:0]) * 48'(frames_r);
        dhi_r <= 32'(cfg.fade_step[62:32]) * 32'(frames_r);
      end
      S_MUL2: begin
        gp_r <= 32'(coeff_r) * 32'(sq16);
        d_r  <= {16'd0, dlo_r} + {dhi_r, 32'd0};
      end
      S_MUL3: begin
        p_r <= 48'(x_r) * 48'(mul_g);
      end
      default: begin
      end
    endcase
  end

  // envelope and frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      envelope       <= '0;
      silence_frames <= '0;
      fade_frames    <= '0;
    end else begin
      if (state == S_MUL3 && op_r == pgmf_pkg::OP_FADE && bend_r) begin
        fade_frames <= fade_frames + 32'(frames_r);
        if (cfg.envelope_dir == pgmf_pkg::DIR_UP) begin
          envelope <= envelope + d_r;
        end else begin
          envelope <= envelope - d_r;
        end
      end
      if (state == S_OUT && out_free && op_r == pgmf_pkg::OP_MUTE && bend_r) begin
        silence_frames <= silence_frames + 32'(frames_r);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      res_valid <= 1'b1;
    end else if (out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_sample <= y;
      out_ch     <= ch_r;
      out_bend   <= bend_r;
      out_ffd    <= fade_frames;
    end
  end

  assign out.valid            = res_valid;
  assign out.sample_out       = out_sample;
  assign out.out_channel      = out_ch;
  assign out.out_block_end    = out_bend;
  assign out.fade_frames_done = out_ffd;

endmodule

// File: sv/pgmf_checker.sv
// pgmf_checker: port-level assertions for pcm_gain_mute_fade_core and its bind
// depends on pgmf_pkg

module pgmf_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_vld,
  input logic                              in_ready,
  input logic                              in_cmd,
  input logic                              out_vld,
  input logic                              out_ready,
  input logic [pgmf_pkg::SAMPLE_W-1:0]     out_sample,
  input logic                              out_block_end,
  input logic [pgmf_pkg::COUNT_W-1:0]      out_ffd
);

  logic [7:0]                    pending;
  logic [pgmf_pkg::COUNT_W-1:0]  prev_ffd;
  logic                          have_prev;
  logic                          in_acc;
  logic                          out_acc;

  assign in_acc  = in_vld && in_ready && (in_cmd == pgmf_pkg::CMD_SAMPLE);
  assign out_acc = out_vld && out_ready;

  // sample transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      have_prev <= 1'b0;
    end else begin
      pending <= pending + {7'd0, in_acc} - {7'd0, out_acc};
      if (out_acc) begin
        have_prev <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      prev_ffd <= out_ffd;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_vld)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_vld && !out_ready |=> out_vld && $stable(out_sample) && $stable(out_ffd))
    else $error("stalled result changed");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> pending != '0)
    else $error("result without an accepted sample");

  a_ffd_steady: assert property (@(posedge clk) disable iff (rst)
    out_acc && have_prev && !out_block_end |-> out_ffd == prev_ffd)
    else $error("fade frame count moved without a block end");

endmodule

bind pcm_gain_mute_fade_core pgmf_checker u_pgmf_checker (
  .clk           (clk),
  .rst           (rst),
  .in_vld        (in.valid),
  .in_ready      (in.ready),
  .in_cmd        (in.cmd),
  .out_vld       (out.valid),
  .out_ready     (out.ready),
  .out_sample    (out.sample_out),
  .out_block_end (out.out_block_end),
  .out_ffd       (out.fade_frames_done)
);

// File: test/pcm_gain_mute_fade_core_tb.sv
// pcm_gain_mute_fade_core_tb: self-checking bench for the pcm gain/mute/fade core
// drives sample and coefficient transactions and checks every result against an
// in-bench gain predictor; depends on pgmf_pkg, pgmf_in_if, pgmf_out_if and the core

module pcm_gain_mute_fade_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pgmf_pkg::*;

  localparam int MAX_CH      = 8;
  localparam int CYCLE_LIMIT = 400000;
  // idle cycles before a register write: covers a coefficient write still in flight
  localparam int SETTLE      = 24;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 75;

  // gain mode code with no function in the core, samples pass through
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic WIDTH_16 = 1'b0;
  localparam logic WIDTH_32 = 1'b1;

  // one input transaction as the bench builds it
  typedef struct {
    logic                 cmd;
    logic [CH_W-1:0]      ch;
    logic [SAMPLE_W-1:0]  smp;
    logic [COEFF_W-1:0]   coeff;
    logic                 bend;
    logic [FRAMES_W-1:0]  frames;
  } pcm_item_t;

  // one expected result transaction
  typedef struct {
    logic [SAMPLE_W-1:0] smp;
    logic [CH_W-1:0]     ch;
    logic                bend;
    logic [COUNT_W-1:0]  frames_done;
  } pcm_result_t;

  // gain predictor: tracks registers, coefficient table, envelope and frame
  // counters, and holds the results still owed by the core in arrival order
  class gain_tracker;
    logic [1:0]                mode;
    logic                      dir;
    logic [STEP_W-1:0]         step;
    logic                      wide;
    logic [ENV_W-1:0]          envelope;
    logic signed [COEFF_W-1:0] coeffs [MAX_CH];
    logic [COUNT_W-1:0]        fade_count;
    logic [COUNT_W-1:0]        silence_count;
    pcm_result_t               owed_results [$];
    int errors;
    int checked;
    int sample_count;
    int coeff_count;

    function new();
      mode = MODE_STATIC;
      dir = DIR_UP;
      step = '0;
      wide = WIDTH_32;
      envelope = '0;
      foreach (coeffs[i]) coeffs[i] = UNITY_COEFF;
      fade_count = '0;
      silence_count = '0;
      errors = 0;
      checked = 0;
      sample_count = 0;
      coeff_count = 0;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_GAIN_MODE:  mode = data[1:0];
        REG_ENV_DIR:    dir = data[0];
        REG_FADE_STEP:  step = data[STEP_W-1:0];
        REG_WIDTH_MODE: wide = data[0];
        default: ;
      endcase
    endfunction

    // round half up with arithmetic shifts
    function longint round_q(longint p, int unsigned s);
      return ((p >>> (s - 1)) + 1) >>> 1;
    endfunction

    function longint clamp(longint v);
      longint hi;
      longint lo;
      hi = wide ? 2147483647 : 32767;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function void note_transaction(pcm_item_t it);
      logic signed [SAMPLE_W-1:0] s32;
      logic signed [15:0]         s16;
      logic signed [COEFF_W-1:0]  k;
      logic signed [15:0]         e;
      logic signed [15:0]         sq;
      logic signed [15:0]         g;
      logic [ENV_W-1:0]           delta;
      longint                     x;
      longint                     y;
      longint                     t;
      pcm_result_t                r;
      if (it.cmd == CMD_COEFF) begin
        if (it.ch < MAX_CH) coeffs[it.ch] = it.coeff;
        coeff_count++;
        return;
      end
      sample_count++;
      k = (it.ch < MAX_CH) ? coeffs[it.ch] : UNITY_COEFF;
      s32 = it.smp;
      s16 = it.smp[15:0];
      if (wide) x = longint'(s32);
      else x = longint'(s16);
      case (mode)
        MODE_STATIC: y = clamp(round_q(x * longint'(k), 10));
        MODE_MUTE:   y = 0;
        MODE_FADE: begin
          // square and gain are held in 16 bits and wrap
          e = envelope[ENV_W-1:ENV_W-16];
          t = round_q(longint'(e) * longint'(e), 15);
          sq = t[15:0];
          t = round_q(longint'(k) * longint'(sq), 15);
          g = t[15:0];
          y = clamp(round_q(x * longint'(g), 10));
        end
        default: y = x;
      endcase
      if (it.bend) begin
        if (mode == MODE_MUTE) begin
          silence_count += it.frames;
        end else if (mode == MODE_FADE) begin
          delta = {1'b0, step} * {48'd0, it.frames};
          fade_count += it.frames;
          if (dir == DIR_UP) envelope = envelope + delta;
          else envelope = envelope - delta;
        end
      end
      r.smp = y[31:0];
      r.ch = it.ch;
      r.bend = it.bend;
      r.frames_done = fade_count;
      owed_results.push_back(r);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
      end
    endfunction

    function void check_sample(logic [SAMPLE_W-1:0] smp, logic [CH_W-1:0] ch,
                               logic bend, logic [COUNT_W-1:0] frames_done);
      pcm_result_t want;
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none actual sample %h channel %0d",
                 $time, smp, ch);
        return;
      end
      want = owed_results.pop_front();
      checked++;
      compare_field("sample_out", want.smp, smp);
      compare_field("out_channel", 32'(want.ch), 32'(ch));
      compare_field("out_block_end", 32'(want.bend), 32'(bend));
      compare_field("fade_frames_done", want.frames_done, frames_done);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pgmf_in_if  in_ch();
  pgmf_out_if out_ch();

  pcm_gain_mute_fade_core #(
    .MAX_CHANNELS(MAX_CH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in(in_ch),
    .out(out_ch)
  );

  gain_tracker tracker = new();
  int cycles;
  int burst_left;
  int config_count;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // both handshakes are sampled at the same edge by one process: the result
  // transaction is checked first, then the input transaction is predicted, so
  // nothing depends on the order of processes within the edge
  always @(posedge clk) begin
    pcm_item_t seen;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        tracker.check_sample(out_ch.sample_out, out_ch.out_channel,
                             out_ch.out_block_end, out_ch.fade_frames_done);
      end
      if (in_ch.valid && in_ch.ready) begin
        seen.cmd = in_ch.cmd;
        seen.ch = in_ch.channel;
        seen.smp = in_ch.sample_in;
        seen.coeff = in_ch.coeff_value;
        seen.bend = in_ch.block_end;
        seen.frames = in_ch.block_frames;
        tracker.note_transaction(seen);
      end
    end
  end

  // result sink: the stall style is redrawn periodically among always ready,
  // coin flips, a sparse periodic ready, and long stalls
  initial begin : sink_stalls
    int style;
    int cnt;
    style = 0;
    cnt = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (cnt % 48 == 0) style = $urandom_range(0, 3);
      cnt++;
      case (style)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= 1'($urandom_range(0, 1));
        2:       out_ch.ready <= (cnt % 6 == 0);
        default: out_ch.ready <= (cnt % 32) >= 20;
      endcase
    end
  end

  // hang guard
  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles with %0d results outstanding",
             cycles, tracker.pending());
    $display("pcm_gain_mute_fade_core verification failed");
    $finish;
  end

  function automatic pcm_item_t sample_item(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] smp,
                                            logic bend, logic [FRAMES_W-1:0] frames);
    pcm_item_t it;
    it.cmd = CMD_SAMPLE;
    it.ch = ch;
    it.smp = smp;
    it.coeff = 16'($urandom);
    it.bend = bend;
    it.frames = frames;
    return it;
  endfunction

  function automatic pcm_item_t coeff_item(logic [CH_W-1:0] ch, logic [COEFF_W-1:0] value);
    pcm_item_t it;
    it.cmd = CMD_COEFF;
    it.ch = ch;
    it.smp = $urandom;
    it.coeff = value;
    it.bend = 1'($urandom_range(0, 1));
    it.frames = 16'($urandom);
    return it;
  endfunction

  // mostly samples; coefficients cluster near unity with the extremes mixed in,
  // samples mix full-scale corners, full random and small magnitudes
  function automatic pcm_item_t random_item();
    pcm_item_t it;
    logic [SAMPLE_W-1:0] v;
    it.cmd = ($urandom_range(0, 5) == 0) ? CMD_COEFF : CMD_SAMPLE;
    it.ch = CH_W'($urandom_range(0, MAX_CH - 1));
    case ($urandom_range(0, 3))
      0:       it.coeff = 16'($urandom);
      1:       it.coeff = 16'($urandom_range(0, 2048));
      2:       it.coeff = 16'(0 - $urandom_range(0, 2048));
      default: it.coeff = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    endcase
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 5))
          0:       it.smp = 32'h7FFF_FFFF;
          1:       it.smp = 32'h8000_0000;
          2:       it.smp = 32'h0000_0000;
          3:       it.smp = 32'hFFFF_FFFF;
          4:       it.smp = 32'h0000_7FFF;
          default: it.smp = 32'hFFFF_8000;
        endcase
      end
      1: begin
        v = $urandom >> $urandom_range(0, 31);
        it.smp = $urandom_range(0, 1) ? v : ~v;
      end
      default: it.smp = $urandom;
    endcase
    it.bend = ($urandom_range(0, 3) == 0);
    it.frames = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64));
    return it;
  endfunction

  function automatic logic [STEP_W-1:0] random_step();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return STEP_W'(raw >> $urandom_range(1, 40));
  endfunction

  // one input transaction; the sender works in bursts with random gaps between
  // them, and a third of the gaps are empty so back-to-back stretches occur
  task automatic send(pcm_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.cmd <= it.cmd;
    in_ch.channel <= it.ch;
    in_ch.sample_in <= it.smp;
    in_ch.coeff_value <= it.coeff;
    in_ch.block_end <= it.bend;
    in_ch.block_frames <= it.frames;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop sending until every owed result has come back
  task automatic hold_until_empty();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    tracker.configure(idx, data);
  endtask

  // registers only change with the core idle: drain, let any coefficient
  // write finish, then write all four
  task automatic program_regs(logic [1:0] mode, logic dir, logic [STEP_W-1:0] step,
                              logic wide);
    hold_until_empty();
    repeat (SETTLE) @(posedge clk);
    write_reg(REG_GAIN_MODE, CFG_DATA_W'(mode));
    write_reg(REG_ENV_DIR, CFG_DATA_W'(dir));
    write_reg(REG_FADE_STEP, CFG_DATA_W'(step));
    write_reg(REG_WIDTH_MODE, CFG_DATA_W'(wide));
    cfg_we <= 1'b0;
    @(posedge clk);
    config_count++;
  endtask

  initial begin : stimulus
    logic [1:0]        mode;
    logic [STEP_W-1:0] step;
    int                hold_at;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.cmd <= CMD_SAMPLE;
    in_ch.channel <= '0;
    in_ch.sample_in <= '0;
    in_ch.coeff_value <= '0;
    in_ch.block_end <= 1'b0;
    in_ch.block_frames <= '0;
    burst_left = 0;
    config_count = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, static gain, 32-bit: unity keeps the corners, a full
    // scale positive or negative coefficient saturates both ways
    send(sample_item(3'd0, 32'h7FFF_FFFF, 1'b0, 16'd0));
    send(sample_item(3'd0, 32'h8000_0000, 1'b0, 16'd0));
    send(coeff_item(3'd1, 16'h7FFF));
    send(sample_item(3'd1, 32'h7FFF_FFFF, 1'b0, 16'd0));
    send(sample_item(3'd1, 32'h8000_0000, 1'b0, 16'd0));
    send(coeff_item(3'd2, 16'h8000));
    send(sample_item(3'd2, 32'h8000_0000, 1'b0, 16'd0));
    // half gain: plus one half rounds up, minus one half rounds to zero
    send(coeff_item(3'd3, 16'd512));
    send(sample_item(3'd3, 32'h0000_0001, 1'b0, 16'd0));
    send(sample_item(3'd3, 32'hFFFF_FFFF, 1'b0, 16'd0));
    // block end in static mode leaves counters and envelope alone
    send(sample_item(3'd7, 32'h1234_5678, 1'b1, 16'hFFFF));

    // 16-bit samples: upper half ignored, saturation at 16 bits
    program_regs(MODE_STATIC, DIR_UP, '0, WIDTH_16);
    send(sample_item(3'd1, 32'h1234_7FFF, 1'b0, 16'd0));
    send(sample_item(3'd2, 32'h0000_8000, 1'b0, 16'd0));

    // mute with a full block end
    program_regs(MODE_MUTE, DIR_UP, '0, WIDTH_32);
    send(sample_item(3'd0, 32'h7FFF_FFFF, 1'b1, 16'hFFFF));

    // fade rising to an envelope of 0x8000 on top: the square wraps to
    // -32768 in 16 bits and turns the gain negative
    program_regs(MODE_FADE, DIR_UP, 63'h4000_0000_0000_0000, WIDTH_32);
    send(sample_item(3'd0, 32'h7FFF_FFFF, 1'b1, 16'd2));
    send(sample_item(3'd1, 32'h7FFF_FFFF, 1'b0, 16'd0));
    send(sample_item(3'd0, 32'h4000_0000, 1'b1, 16'hFFFF));

    // fade falling with the largest step, negative coefficient
    program_regs(MODE_FADE, DIR_DOWN, '1, WIDTH_32);
    send(sample_item(3'd4, 32'h7FFF_FFFF, 1'b1, 16'hFFFF));
    send(coeff_item(3'd4, 16'h8000));
    send(sample_item(3'd4, 32'h8000_0000, 1'b1, 16'd1));

    // unused mode passes samples through at the selected width
    program_regs(MODE_UNUSED, DIR_UP, '0, WIDTH_16);
    send(sample_item(3'd5, 32'hABCD_8001, 1'b1, 16'd100));
    send(sample_item(3'd6, 32'h0001_7FFF, 1'b0, 16'd0));

    // random phases: fade in half of them with both directions and step
    // extremes, static, mute and the unused mode in the rest
    for (int p = 0; p < PHASES; p++) begin
      case (p % 6)
        1:       mode = MODE_STATIC;
        3:       mode = MODE_MUTE;
        5:       mode = (p == 5) ? MODE_UNUSED : MODE_STATIC;
        default: mode = MODE_FADE;
      endcase
      if (p == 2) step = '1;
      else if (p == 4) step = '0;
      else step = random_step();
      program_regs(mode, 1'(p >> 1), step, (p % 3 != 0) ? WIDTH_32 : WIDTH_16);
      hold_at = $urandom_range(10, PHASE_ITEMS - 10);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == hold_at) hold_until_empty();
        send(random_item());
      end
    end

    hold_until_empty();
    repeat (SETTLE) @(posedge clk);

    $display("drove %0d sample and %0d coefficient transactions over %0d register settings",
             tracker.sample_count, tracker.coeff_count, config_count);
    $display("checked %0d results in %0d cycles, %0d mismatches",
             tracker.checked, cycles, tracker.errors);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("pcm_gain_mute_fade_core verification clean");
    end else begin
      $display("pcm_gain_mute_fade_core verification failed");
    end
    $finish;
  end

endmodule
